/* hw/rtl/rwlk_pkg.sv */
// ----------------------------------------------------------------------------
// rwlk_pkg: shared types and constants for the leg kinematics core
// Beat formats, configuration register indexes, CORDIC constants and the
// flag group passed along the divider cells.
// ----------------------------------------------------------------------------
package rwlk_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int XW = 34;
    localparam int AW = 36;
    localparam int QW = 32;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 24;

    localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [QW-1:0] MAG_POS     = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] MAG_NEG     = 32'sh8000_0001;

    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687, 32'd33543516, 32'd16775851, 32'd8388437,
        32'd4194283, 32'd2097149, 32'd1048576, 32'd524288,
        32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048,
        32'd1024, 32'd512, 32'd256, 32'd128,
        32'd64, 32'd32, 32'd16, 32'd8,
        32'd4, 32'd2, 32'd1, 32'd0
    };

    typedef enum logic [CFG_IW-1:0] {
        CFG_LINK_LENGTH,
        CFG_THIGH_MASS,
        CFG_SHANK_MASS,
        CFG_THIGH_COM_OFFSET,
        CFG_SHANK_COM_OFFSET,
        CFG_THIGH_OWN_INERTIA,
        CFG_SHANK_OWN_INERTIA
    } t_cfg_index;

    typedef struct packed {
        logic signed [15:0] first_angle;
        logic signed [15:0] second_angle;
        logic signed [15:0] knee_angle;
        logic signed [15:0] rate_zero;
        logic signed [15:0] rate_one;
        logic signed [15:0] rate_two;
    } t_in_beat;

    typedef struct packed {
        logic        [15:0] leg_length;
        logic signed [15:0] leg_angle;
        logic signed [15:0] hip_angle;
        logic signed [31:0] length_velocity;
        logic signed [31:0] swing_velocity;
        logic signed [31:0] spread_velocity;
        logic signed [31:0] inertia_radial;
        logic signed [31:0] inertia_coupled;
        logic signed [31:0] inertia_angular;
        logic signed [31:0] inverse_gain_cos;
        logic signed [31:0] inverse_gain_sin;
        logic               singular;
    } t_out_beat;

    typedef struct packed {
        logic neg;
        logic dz;
        logic nz;
    } t_div_flags;

endpackage

/* hw/rtl/rwlk_cordic_cell.sv */
// ----------------------------------------------------------------------------
// rwlk_cordic_cell: one rotation-mode CORDIC iteration
// Rotates the vector by the fixed angle of its stage and hands the result on.
// ----------------------------------------------------------------------------
module rwlk_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [rwlk_pkg::XW-1:0]    i_x,
    input  logic signed [rwlk_pkg::XW-1:0]    i_y,
    input  logic signed [rwlk_pkg::AW-1:0]    i_z,
    output logic signed [rwlk_pkg::XW-1:0]    o_x,
    output logic signed [rwlk_pkg::XW-1:0]    o_y,
    output logic signed [rwlk_pkg::AW-1:0]    o_z
);
    import rwlk_pkg::*;

    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    logic signed [AW-1:0] w_step;
    logic                 w_pos;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [AW-1:0] r_z;

    assign w_dx   = i_y >>> STAGE;
    assign w_dy   = i_x >>> STAGE;
    assign w_step = AW'(ATAN_Q30[STAGE]);
    assign w_pos  = ~i_z[AW-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= w_pos ? i_x - w_dx : i_x + w_dx;
            r_y <= w_pos ? i_y + w_dy : i_y - w_dy;
            r_z <= w_pos ? i_z - w_step : i_z + w_step;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

/* hw/rtl/rwlk_div_cell.sv */
// ----------------------------------------------------------------------------
// rwlk_div_cell: one restoring division step
// Subtracts the aligned divisor when it fits, records one quotient bit and
// moves the divisor one place down for the next cell.
// ----------------------------------------------------------------------------
module rwlk_div_cell #(
    parameter int W = 64
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [W-1:0]                 i_rem,
    input  logic [W-1:0]                 i_dsr,
    input  logic [rwlk_pkg::QW-1:0]      i_quot,
    input  rwlk_pkg::t_div_flags         i_flg,
    output logic [W-1:0]                 o_rem,
    output logic [W-1:0]                 o_dsr,
    output logic [rwlk_pkg::QW-1:0]      o_quot,
    output rwlk_pkg::t_div_flags         o_flg
);
    import rwlk_pkg::*;

    logic          w_fit;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_dsr;
    logic [QW-1:0] r_quot;
    t_div_flags    r_flg;

    assign w_fit = (i_rem >= i_dsr);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_fit ? i_rem - i_dsr : i_rem;
            r_dsr  <= i_dsr >> 1;
            r_quot <= {i_quot[QW-2:0], w_fit};
            r_flg  <= i_flg;
        end
    end

    assign o_rem  = r_rem;
    assign o_dsr  = r_dsr;
    assign o_quot = r_quot;
    assign o_flg  = r_flg;

endmodule

/* hw/rtl/rwlk_divider.sv */
// ----------------------------------------------------------------------------
// rwlk_divider: pipelined saturating divider
// Computes the truncated quotient (num << SH) / den as a signed value whose
// magnitude saturates at 2^31-1, through a row of division cells.
// ----------------------------------------------------------------------------
module rwlk_divider #(
    parameter int NW = 47,
    parameter int DW = 66,
    parameter int SH = 44
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [NW-1:0]                     i_num,
    input  logic [DW-1:0]                     i_den,
    input  logic                              i_neg,
    output logic signed [rwlk_pkg::QW-1:0]    o_quot,
    output logic                              o_sing
);
    import rwlk_pkg::*;

    localparam int W = (NW + SH > DW + QW - 1) ? NW + SH : DW + QW - 1;

    logic [W-1:0]  w_rem  [0:QW];
    logic [W-1:0]  w_dsr  [0:QW];
    logic [QW-1:0] w_quot [0:QW];
    t_div_flags    w_flg  [0:QW];
    logic [QW-1:0] w_q;
    t_div_flags    w_f;
    logic signed [QW-1:0] w_pos;

    assign w_rem[0]  = W'(i_num) << SH;
    assign w_dsr[0]  = W'(i_den) << (QW - 1);
    assign w_quot[0] = '0;
    assign w_flg[0]  = '{neg: i_neg, dz: (i_den == '0), nz: (i_num != '0)};

    for (genvar k = 0; k < QW; k++) begin : g_cell
        rwlk_div_cell #(.W(W)) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_rem  (w_rem[k]),
            .i_dsr  (w_dsr[k]),
            .i_quot (w_quot[k]),
            .i_flg  (w_flg[k]),
            .o_rem  (w_rem[k+1]),
            .o_dsr  (w_dsr[k+1]),
            .o_quot (w_quot[k+1]),
            .o_flg  (w_flg[k+1])
        );
    end

    assign w_q   = w_quot[QW];
    assign w_f   = w_flg[QW];
    assign w_pos = $signed({1'b0, w_q[QW-2:0]});

    always_comb begin
        if (w_f.dz) begin
            o_sing = 1'b1;
            o_quot = w_f.nz ? (w_f.neg ? MAG_NEG : MAG_POS) : '0;
        end else if (w_q[QW-1]) begin
            o_sing = 1'b1;
            o_quot = w_f.neg ? MAG_NEG : MAG_POS;
        end else begin
            o_sing = 1'b0;
            o_quot = w_f.neg ? -w_pos : w_pos;
        end
    end

endmodule

/* hw/rtl/rotating_workspace_leg_kinematics_core.sv */
// ----------------------------------------------------------------------------
// rotating_workspace_leg_kinematics_core: two-link leg kinematics pipeline
// Leg position, Jacobian velocities, workspace inertias and inverse gains.
// ----------------------------------------------------------------------------
// The core takes one beat per clock and returns each result through one register
// per CORDIC cell, five arithmetic stages, 32 divider cells and the output
// register. The whole pipeline holds while a result waits at the output. Terms
// derived from the configuration registers settle through a chain of registers
// after a write.
module rotating_workspace_leg_kinematics_core #(
    parameter int CORDIC_STAGES = rwlk_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rwlk_pkg::t_in_beat            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rwlk_pkg::t_out_beat           o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rwlk_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [rwlk_pkg::CFG_DW-1:0]   i_cfg_data
);
    import rwlk_pkg::*;

    localparam int NS  = CORDIC_STAGES;
    localparam int TOT = NS + 38;

    typedef struct packed {
        logic signed [15:0] a0;
        logic signed [15:0] a1;
        logic signed [15:0] r0;
        logic signed [15:0] r1;
        logic signed [15:0] r2;
        logic               fd;
        logic               fk;
    } t_cside;

    typedef struct packed {
        logic        [15:0] len;
        logic signed [15:0] leg;
        logic signed [15:0] hip;
        logic signed [31:0] vlen;
        logic signed [31:0] vsw;
        logic signed [31:0] vsp;
    } t_post;

    logic w_adv;
    logic [TOT-1:0] r_vld;

    logic [15:0] r_link, r_mt, r_ms, r_dt, r_ds;
    logic [23:0] r_it, r_is;
    logic [31:0] r_c_mtdt, r_c_msds, r_c_msl;
    logic [47:0] r_c_pt, r_c_ps, r_c_pl, r_c_pe;
    logic [40:0] r_c_jt, r_c_js;
    logic [39:0] r_c_pl8, r_c_msdl;
    logic [41:0] r_c_base;
    logic [42:0] r_c_sumb;
    logic signed [43:0] r_c_diffb;

    logic signed [16:0]   w_diff;
    logic signed [AW-1:0] w_angd_raw, w_angk_raw, w_angd, w_angk;
    logic                 w_fd, w_fk;
    t_cside               w_cside;

    logic signed [XW-1:0] w_dx [0:NS];
    logic signed [XW-1:0] w_dy [0:NS];
    logic signed [AW-1:0] w_dz [0:NS];
    logic signed [XW-1:0] w_kx [0:NS];
    logic signed [XW-1:0] w_ky [0:NS];
    logic signed [AW-1:0] w_kz [0:NS];
    t_cside               r_cs [0:NS-1];

    logic signed [XW-1:0] w_cd, w_c, w_s;
    logic signed [50:0] r_m1_lcd, r_m1_lc, r_m1_ls;
    logic signed [67:0] r_m1_cc, r_m1_ss;
    t_cside             r_m1_side;

    logic signed [50:0] w_len_t, w_gc_t, w_gs_t;
    logic signed [68:0] w_cdiff, w_cosk_t;
    logic signed [35:0] w_gc, w_gs, w_ngc, w_ngs;
    logic signed [16:0] w_asum;
    logic [15:0]        w_len;
    logic [15:0]        r_m2_len;
    logic signed [15:0] r_m2_leg, r_m2_hip, r_m2_r0;
    logic signed [35:0] r_m2_gc, r_m2_gs;
    logic [32:0]        r_m2_mgc, r_m2_mgs;
    logic signed [23:0] r_m2_cosk;
    logic signed [16:0] r_m2_rsum, r_m2_rdif;

    logic signed [52:0] r_m3_pvl, r_m3_pvp;
    logic signed [51:0] r_m3_pvs;
    logic signed [64:0] r_m3_pe;
    logic [65:0]        r_m3_dss, r_m3_dsc, r_m3_dcc;
    logic [32:0]        r_m3_mgc, r_m3_mgs;
    logic               r_m3_sgc, r_m3_sgs;
    logic [15:0]        r_m3_len;
    logic signed [15:0] r_m3_leg, r_m3_hip;

    logic signed [52:0] w_vl_t, w_vp_t;
    logic signed [51:0] w_vs_t;
    logic signed [64:0] w_e_t;
    logic signed [47:0] w_e2, w_sb;
    t_post              r_m4_post;
    logic signed [47:0] r_m4_jrt, r_m4_jrc, r_m4_jrs;
    logic [65:0]        r_m4_dss, r_m4_dsc, r_m4_dcc;
    logic [32:0]        r_m4_mgc, r_m4_mgs;
    logic               r_m4_sgc, r_m4_sgs;

    logic signed [47:0] w_njrt, w_njrc, w_njrs;
    t_post              r_m5_post;
    logic [46:0]        r_m5_nrad, r_m5_ncpl, r_m5_nang;
    logic               r_m5_grad, r_m5_gcpl, r_m5_gang;
    logic [65:0]        r_m5_dss, r_m5_dsc, r_m5_dcc;
    logic [32:0]        r_m5_mgc, r_m5_mgs;
    logic               r_m5_sgc, r_m5_sgs;

    t_post              r_dly [0:QW-1];
    logic signed [QW-1:0] w_qrad, w_qcpl, w_qang, w_qgc, w_qgs;
    logic               w_srad, w_scpl, w_sang, w_sgc, w_sgs;
    t_out_beat          r_out;

    assign w_adv       = ~r_vld[TOT-1] | i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_vld[TOT-1];
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[TOT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= 16'd16384;
            r_mt   <= 16'd256;
            r_ms   <= 16'd256;
            r_dt   <= 16'd8192;
            r_ds   <= 16'd8192;
            r_it   <= 24'd167772;
            r_is   <= 24'd167772;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LINK_LENGTH:       r_link <= i_cfg_data[15:0];
                CFG_THIGH_MASS:        r_mt   <= i_cfg_data[15:0];
                CFG_SHANK_MASS:        r_ms   <= i_cfg_data[15:0];
                CFG_THIGH_COM_OFFSET:  r_dt   <= i_cfg_data[15:0];
                CFG_SHANK_COM_OFFSET:  r_ds   <= i_cfg_data[15:0];
                CFG_THIGH_OWN_INERTIA: r_it   <= i_cfg_data;
                CFG_SHANK_OWN_INERTIA: r_is   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_mtdt  <= r_mt * r_dt;
        r_c_msds  <= r_ms * r_ds;
        r_c_msl   <= r_ms * r_link;
        r_c_pt    <= r_c_mtdt * r_dt;
        r_c_ps    <= r_c_msds * r_ds;
        r_c_pl    <= r_c_msl * r_link;
        r_c_pe    <= r_c_msds * r_link;
        r_c_jt    <= {9'd0, r_it, 8'd0} + 41'(r_c_pt[47:8]);
        r_c_js    <= {9'd0, r_is, 8'd0} + 41'(r_c_ps[47:8]);
        r_c_pl8   <= r_c_pl[47:8];
        r_c_msdl  <= r_c_pe[47:8];
        r_c_base  <= 42'(r_c_jt) + 42'(r_c_pl8);
        r_c_sumb  <= 43'(r_c_base) + 43'(r_c_js);
        r_c_diffb <= $signed({2'b00, r_c_base}) - $signed({3'b000, r_c_js});
    end

    assign w_diff     = {i_in_data.second_angle[15], i_in_data.second_angle}
                      - {i_in_data.first_angle[15], i_in_data.first_angle};
    assign w_angd_raw = $signed({{3{w_diff[16]}}, w_diff, 16'h0000});
    assign w_angk_raw = $signed({{4{i_in_data.knee_angle[15]}}, i_in_data.knee_angle,
                                 16'h0000});

    always_comb begin
        w_angd = w_angd_raw;
        w_fd   = 1'b0;
        if (w_angd_raw > HALF_PI_Q30) begin
            w_angd = w_angd_raw - PI_Q30;
            w_fd   = 1'b1;
        end else if (w_angd_raw < -HALF_PI_Q30) begin
            w_angd = w_angd_raw + PI_Q30;
            w_fd   = 1'b1;
        end
        w_angk = w_angk_raw;
        w_fk   = 1'b0;
        if (w_angk_raw > HALF_PI_Q30) begin
            w_angk = w_angk_raw - PI_Q30;
            w_fk   = 1'b1;
        end else if (w_angk_raw < -HALF_PI_Q30) begin
            w_angk = w_angk_raw + PI_Q30;
            w_fk   = 1'b1;
        end
    end

    assign w_cside = '{a0: i_in_data.first_angle, a1: i_in_data.second_angle,
                       r0: i_in_data.rate_zero, r1: i_in_data.rate_one,
                       r2: i_in_data.rate_two, fd: w_fd, fk: w_fk};

    assign w_dx[0] = GAIN_Q30;
    assign w_dy[0] = '0;
    assign w_dz[0] = w_angd;
    assign w_kx[0] = GAIN_Q30;
    assign w_ky[0] = '0;
    assign w_kz[0] = w_angk;

    for (genvar k = 0; k < NS; k++) begin : g_cordic
        rwlk_cordic_cell #(.STAGE(k)) u_diff (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_x   (w_dx[k]),
            .i_y   (w_dy[k]),
            .i_z   (w_dz[k]),
            .o_x   (w_dx[k+1]),
            .o_y   (w_dy[k+1]),
            .o_z   (w_dz[k+1])
        );
        rwlk_cordic_cell #(.STAGE(k)) u_knee (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_x   (w_kx[k]),
            .i_y   (w_ky[k]),
            .i_z   (w_kz[k]),
            .o_x   (w_kx[k+1]),
            .o_y   (w_ky[k+1]),
            .o_z   (w_kz[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cs[0] <= w_cside;
            for (int k = 1; k < NS; k++) begin
                r_cs[k] <= r_cs[k-1];
            end
        end
    end

    assign w_cd = r_cs[NS-1].fd ? -w_dx[NS] : w_dx[NS];
    assign w_c  = r_cs[NS-1].fk ? -w_kx[NS] : w_kx[NS];
    assign w_s  = r_cs[NS-1].fk ? -w_ky[NS] : w_ky[NS];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1_lcd  <= $signed({1'b0, r_link}) * w_cd;
            r_m1_lc   <= $signed({1'b0, r_link}) * w_c;
            r_m1_ls   <= $signed({1'b0, r_link}) * w_s;
            r_m1_cc   <= w_c * w_c;
            r_m1_ss   <= w_s * w_s;
            r_m1_side <= r_cs[NS-1];
        end
    end

    assign w_len_t  = r_m1_lcd >>> 30;
    assign w_gc_t   = r_m1_lc >>> 15;
    assign w_gs_t   = r_m1_ls >>> 15;
    assign w_gc     = w_gc_t[35:0];
    assign w_gs     = w_gs_t[35:0];
    assign w_ngc    = -w_gc;
    assign w_ngs    = -w_gs;
    assign w_cdiff  = r_m1_cc - r_m1_ss;
    assign w_cosk_t = w_cdiff >>> 40;
    assign w_asum   = r_m1_side.a0 + r_m1_side.a1;

    always_comb begin
        if (w_len_t < 0) begin
            w_len = '0;
        end else if (w_len_t > 51'sd65535) begin
            w_len = 16'hFFFF;
        end else begin
            w_len = w_len_t[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m2_len  <= w_len;
            r_m2_leg  <= w_asum[16:1];
            r_m2_hip  <= r_m1_side.a0;
            r_m2_gc   <= w_gc;
            r_m2_gs   <= w_gs;
            r_m2_mgc  <= w_gc[35] ? w_ngc[32:0] : w_gc[32:0];
            r_m2_mgs  <= w_gs[35] ? w_ngs[32:0] : w_gs[32:0];
            r_m2_cosk <= w_cosk_t[23:0];
            r_m2_r0   <= r_m1_side.r0;
            r_m2_rsum <= r_m1_side.r1 + r_m1_side.r2;
            r_m2_rdif <= r_m1_side.r1 - r_m1_side.r2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m3_pvl <= r_m2_gc * r_m2_rsum;
            r_m3_pvs <= r_m2_gc * r_m2_r0;
            r_m3_pvp <= r_m2_gs * r_m2_rdif;
            r_m3_pe  <= $signed({1'b0, r_c_msdl}) * r_m2_cosk;
            r_m3_dss <= r_m2_mgs * r_m2_mgs;
            r_m3_dsc <= r_m2_mgs * r_m2_mgc;
            r_m3_dcc <= r_m2_mgc * r_m2_mgc;
            r_m3_mgc <= r_m2_mgc;
            r_m3_mgs <= r_m2_mgs;
            r_m3_sgc <= r_m2_gc[35];
            r_m3_sgs <= r_m2_gs[35];
            r_m3_len <= r_m2_len;
            r_m3_leg <= r_m2_leg;
            r_m3_hip <= r_m2_hip;
        end
    end

    assign w_vl_t = r_m3_pvl >>> 25;
    assign w_vs_t = r_m3_pvs >>> 24;
    assign w_vp_t = r_m3_pvp >>> 25;
    assign w_e_t  = r_m3_pe >>> 20;
    assign w_e2   = $signed({w_e_t[46:0], 1'b0});
    assign w_sb   = $signed({5'd0, r_c_sumb});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m4_post <= '{len: r_m3_len, leg: r_m3_leg, hip: r_m3_hip,
                           vlen: w_vl_t[31:0], vsw: w_vs_t[31:0], vsp: w_vp_t[31:0]};
            r_m4_jrt  <= w_sb - w_e2;
            r_m4_jrc  <= 48'(r_c_diffb);
            r_m4_jrs  <= w_sb + w_e2;
            r_m4_dss  <= r_m3_dss;
            r_m4_dsc  <= r_m3_dsc;
            r_m4_dcc  <= r_m3_dcc;
            r_m4_mgc  <= r_m3_mgc;
            r_m4_mgs  <= r_m3_mgs;
            r_m4_sgc  <= r_m3_sgc;
            r_m4_sgs  <= r_m3_sgs;
        end
    end

    assign w_njrt = -r_m4_jrt;
    assign w_njrc = -r_m4_jrc;
    assign w_njrs = -r_m4_jrs;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m5_post <= r_m4_post;
            r_m5_nrad <= r_m4_jrt[47] ? w_njrt[46:0] : r_m4_jrt[46:0];
            r_m5_ncpl <= r_m4_jrc[47] ? w_njrc[46:0] : r_m4_jrc[46:0];
            r_m5_nang <= r_m4_jrs[47] ? w_njrs[46:0] : r_m4_jrs[46:0];
            r_m5_grad <= r_m4_jrt[47];
            r_m5_gcpl <= r_m4_jrc[47] ^ r_m4_sgs ^ r_m4_sgc;
            r_m5_gang <= r_m4_jrs[47];
            r_m5_dss  <= r_m4_dss;
            r_m5_dsc  <= r_m4_dsc;
            r_m5_dcc  <= r_m4_dcc;
            r_m5_mgc  <= r_m4_mgc;
            r_m5_mgs  <= r_m4_mgs;
            r_m5_sgc  <= r_m4_sgc;
            r_m5_sgs  <= r_m4_sgs;
        end
    end

    rwlk_divider #(.NW(47), .DW(66), .SH(44)) u_div_rad (
        .i_clk (i_clk), .i_en (w_adv), .i_num (r_m5_nrad), .i_den (r_m5_dss),
        .i_neg (r_m5_grad), .o_quot (w_qrad), .o_sing (w_srad)
    );

    rwlk_divider #(.NW(47), .DW(66), .SH(44)) u_div_cpl (
        .i_clk (i_clk), .i_en (w_adv), .i_num (r_m5_ncpl), .i_den (r_m5_dsc),
        .i_neg (r_m5_gcpl), .o_quot (w_qcpl), .o_sing (w_scpl)
    );

    rwlk_divider #(.NW(47), .DW(66), .SH(44)) u_div_ang (
        .i_clk (i_clk), .i_en (w_adv), .i_num (r_m5_nang), .i_den (r_m5_dcc),
        .i_neg (r_m5_gang), .o_quot (w_qang), .o_sing (w_sang)
    );

    rwlk_divider #(.NW(1), .DW(33), .SH(46)) u_div_gcos (
        .i_clk (i_clk), .i_en (w_adv), .i_num (1'b1), .i_den (r_m5_mgc),
        .i_neg (r_m5_sgc), .o_quot (w_qgc), .o_sing (w_sgc)
    );

    rwlk_divider #(.NW(1), .DW(33), .SH(46)) u_div_gsin (
        .i_clk (i_clk), .i_en (w_adv), .i_num (1'b1), .i_den (r_m5_mgs),
        .i_neg (r_m5_sgs), .o_quot (w_qgs), .o_sing (w_sgs)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dly[0] <= r_m5_post;
            for (int k = 1; k < QW; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.leg_length       <= r_dly[QW-1].len;
            r_out.leg_angle        <= r_dly[QW-1].leg;
            r_out.hip_angle        <= r_dly[QW-1].hip;
            r_out.length_velocity  <= r_dly[QW-1].vlen;
            r_out.swing_velocity   <= r_dly[QW-1].vsw;
            r_out.spread_velocity  <= r_dly[QW-1].vsp;
            r_out.inertia_radial   <= w_qrad;
            r_out.inertia_coupled  <= w_qcpl;
            r_out.inertia_angular  <= w_qang;
            r_out.inverse_gain_cos <= w_qgc;
            r_out.inverse_gain_sin <= w_qgs;
            r_out.singular         <= w_srad | w_scpl | w_sang | w_sgc | w_sgs;
        end
    end

endmodule
